### src/mvt_pkg.sv
// Shared constants and types for the 4x4 matrix-vector transform unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package mvt_pkg;

	// Number format
	localparam int FRAC_BITS  = 16;
	localparam int DATA_WIDTH = 32;

	// Fixed slot and register sizes
	localparam int SLOT_W   = 32;
	localparam int REG_W    = 2 * SLOT_W;
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = 4;
	localparam int REG_SEL_W = $clog2(NUM_REGS);
	localparam int NUM_ROWS = 4;
	localparam int NUM_COLS = 4;

	// Datapath widths
	localparam int PROD_W  = 2 * DATA_WIDTH;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SHIFT_W = (SUM_W - FRAC_BITS > DATA_WIDTH) ?
		(SUM_W - FRAC_BITS) : (DATA_WIDTH + 1);

	// Stream payload widths
	localparam int IN_DATA_W  = NUM_COLS * SLOT_W;
	localparam int OUT_DATA_W = NUM_ROWS * SLOT_W;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef logic [NUM_COLS-1:0][DATA_WIDTH-1:0] vec_t;
	typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][DATA_WIDTH-1:0] mat_t;

	// Reset contents of one matrix register: the identity, 1.0 on the diagonal
	function automatic logic [REG_W-1:0] cfg_reset(input logic [REG_SEL_W-1:0] idx);
		logic [REG_W-1:0] one;
		logic [1:0]       row;
		one = REG_W'(1) << FRAC_BITS;
		row = idx[REG_SEL_W-1:1];
		if (idx[0] == row[1]) begin
			return row[0] ? (one << SLOT_W) : one;
		end
		return '0;
	endfunction

endpackage

### src/matrix_vector_transform_4x4.sv
// Top level of the 4x4 matrix-vector transform unit.
// Depends on mvt_pkg, mvt_cfg and mvt_row.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: vec_x, vec_y, vec_z, vec_w
// m_axis    out        m_tvalid/m_tready  m_tdata: out_x..out_w; m_tuser: saturated
// config    in         cfg_we             cfg_idx, cfg_data (one matrix register)
//
// One vector per cycle is taken while the output is not stalled; each result passes
// through four register stages (input, product, sum and saturate, 16 multipliers
// in all) and is then offered on m_axis.
// Reset clears the stage valid bits and loads the identity matrix.
// When the output register holds a result that is not taken, every stage holds
// and s_tready falls; bubbles are filled as soon as the output moves.

module matrix_vector_transform_4x4 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mvt_pkg::IN_DATA_W-1:0]  s_tdata,   // vec_x, vec_y, vec_z, vec_w
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mvt_pkg::OUT_DATA_W-1:0] m_tdata,   // out_x, out_y, out_z, out_w
	output logic                           m_tuser,   // saturated
	input  logic                           cfg_we,
	input  logic [mvt_pkg::IDX_W-1:0]      cfg_idx,
	input  logic [mvt_pkg::REG_W-1:0]      cfg_data
);
	import mvt_pkg::*;

	mat_t                mat;
	vec_t                vec_s1;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                valid_s4;
	logic                en;
	logic [NUM_ROWS-1:0] sat_s4;

	// Advance the whole pipe unless the output is full and stalled
	assign en       = !valid_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_s4;
	assign m_tuser  = |sat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: capture the vector, low data bits of each slot
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				vec_s1[c] <= s_tdata[c * SLOT_W +: DATA_WIDTH];
			end
		end
	end

	mvt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.mat      (mat)
	);

	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		mvt_row u_row (
			.clk    (clk),
			.en     (en),
			.row    (mat[r]),
			.vec_s1 (vec_s1),
			.res_s4 (m_tdata[r * SLOT_W +: SLOT_W]),
			.sat_s4 (sat_s4[r])
		);
	end

endmodule

### src/mvt_cfg.sv
// Matrix register file: eight 64-bit registers, two elements each.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mvt_pkg::IDX_W-1:0] cfg_idx,
	input  logic [mvt_pkg::REG_W-1:0] cfg_data,
	output mvt_pkg::mat_t             mat
);
	import mvt_pkg::*;

	logic [REG_W-1:0] regs_q [NUM_REGS];

	// Write on enable; ignore indexes past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= cfg_reset(REG_SEL_W'(i));
			end
		end else if (cfg_we && (cfg_idx < IDX_W'(NUM_REGS))) begin
			regs_q[cfg_idx[REG_SEL_W-1:0]] <= cfg_data;
		end
	end

	// Unpack elements: even column in the low half, odd column in the high half
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
		for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
			assign mat[r][c] = regs_q[2 * r + c / 2][SLOT_W * (c % 2) +: DATA_WIDTH];
		end
	end

endmodule

### src/mvt_row.sv
// One row of the transform: multiply, sum, shift and saturate in three stages.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_row (
	input  logic                       clk,
	input  logic                       en,
	input  mvt_pkg::vec_t              row,
	input  mvt_pkg::vec_t              vec_s1,
	output logic [mvt_pkg::SLOT_W-1:0] res_s4,
	output logic                       sat_s4
);
	import mvt_pkg::*;

	localparam elem_t DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam elem_t DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	elem_t                    m_elem [NUM_COLS];
	elem_t                    v_elem [NUM_COLS];
	logic signed [PROD_W-1:0] prod_s2 [NUM_COLS];
	logic signed [SUM_W-1:0]  sum_s3;
	logic signed [SHIFT_W-1:0] shifted;
	logic                     over_hi;
	logic                     over_lo;
	elem_t                    clamped;

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_el
		assign m_elem[c] = row[c];
		assign v_elem[c] = vec_s1[c];
	end

	// Stage 2: exact products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				prod_s2[c] <= m_elem[c] * v_elem[c];
			end
		end
	end

	// Stage 3: exact sum of the four products
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1])
				+ SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]);
		end
	end

	// Arithmetic shift, then clamp to the data range
	always_comb begin
		shifted = SHIFT_W'(sum_s3 >>> FRAC_BITS);
		over_hi = shifted > SHIFT_W'(DMAX);
		over_lo = shifted < SHIFT_W'(DMIN);
		priority if (over_hi) begin
			clamped = DMAX;
		end else if (over_lo) begin
			clamped = DMIN;
		end else begin
			clamped = shifted[DATA_WIDTH-1:0];
		end
	end

	// Stage 4: result, sign-extended to the slot
	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= SLOT_W'(clamped);
			sat_s4 <= over_hi || over_lo;
		end
	end

endmodule
